@@ design/fspm_pkg.sv @@
`timescale 1ns / 1ps

package fspm_pkg;

  // Default pool size.
  localparam int DEFAULT_POOL_SLOTS = 8;

  // Fixed field widths of the ports.
  localparam int OPCODE_W     = 2;
  localparam int TAG_W        = 32;
  localparam int HANDLE_W     = 3;
  localparam int STATUS_W     = 2;
  localparam int SLOT_INDEX_W = 3;

  // Opcodes of an input beat.
  localparam logic [OPCODE_W-1:0] OP_ADD     = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_GET     = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd2;

  // Status codes of a result beat.
  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOTHING     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REL_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_ADD_DROPPED = 2'd3;

  // Command classes decided by the front end.
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_ADD,
    CMD_GET,
    CMD_RELEASE,
    CMD_RELEASE_BAD
  } cmd_kind_t;

  // One queued command.
  typedef struct packed {
    cmd_kind_t             kind;
    logic [TAG_W-1:0]      tag;
    logic [HANDLE_W-1:0]   handle;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [SLOT_INDEX_W-1:0] slot_index;
    logic [TAG_W-1:0]        out_tag;
    logic                    evicted;
    logic [TAG_W-1:0]        evicted_tag;
  } result_t;

endpackage

@@ design/fspm_front.sv @@
`timescale 1ns / 1ps

module fspm_front #(
  parameter int POOL_SLOTS = fspm_pkg::DEFAULT_POOL_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fspm_pkg::OPCODE_W-1:0]   opcode,
  input  logic [fspm_pkg::TAG_W-1:0]      frame_tag,
  input  logic [fspm_pkg::HANDLE_W-1:0]   slot_handle,
  output logic                            cmd_valid,
  input  logic                            cmd_pop,
  output fspm_pkg::cmd_t                  cmd
);
  import fspm_pkg::*;

  localparam int          Depth  = 2;
  localparam logic [31:0] SlotsU = POOL_SLOTS;

  cmd_t       queue [Depth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cmd_in;
  logic       in_accept;

  // Classify the incoming beat; a release handle beyond the pool is flagged here.
  always_comb begin
    cmd_in.tag    = frame_tag;
    cmd_in.handle = slot_handle;
    case (opcode)
      OP_ADD: begin
        cmd_in.kind = CMD_ADD;
      end
      OP_GET: begin
        cmd_in.kind = CMD_GET;
      end
      OP_RELEASE: begin
        if (32'(slot_handle) >= SlotsU) begin
          cmd_in.kind = CMD_RELEASE_BAD;
        end else begin
          cmd_in.kind = CMD_RELEASE;
        end
      end
      default: begin
        cmd_in.kind = CMD_NOP;
      end
    endcase
  end

  // Two-entry command queue between front and back.
  assign in_stall  = (count == 2'd2);
  assign in_accept = in_valid && !in_stall;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (in_accept && !cmd_pop) begin
        count <= count + 2'd1;
      end else if (!in_accept && cmd_pop) begin
        count <= count - 2'd1;
      end
    end
  end

  // Queue payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

endmodule

@@ design/fspm_back.sv @@
`timescale 1ns / 1ps

module fspm_back #(
  parameter int POOL_SLOTS = fspm_pkg::DEFAULT_POOL_SLOTS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  input  fspm_pkg::cmd_t     cmd,
  output logic               out_valid,
  input  logic               out_stall,
  output fspm_pkg::result_t  res
);
  import fspm_pkg::*;

  localparam int              SlotW = $clog2(POOL_SLOTS);
  localparam int              LenW  = $clog2(POOL_SLOTS + 1);
  localparam logic [LenW-1:0] Full  = LenW'(POOL_SLOTS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_ROT  = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_RESP = 3'd4;

  localparam logic [1:0] MODE_GET   = 2'd0;
  localparam logic [1:0] MODE_EVICT = 2'd1;
  localparam logic [1:0] MODE_SWEEP = 2'd2;

  logic [2:0]            state;
  logic [1:0]            mode;
  cmd_t                  cur;
  logic [POOL_SLOTS-1:0] valid;
  logic [POOL_SLOTS-1:0] taken;
  logic [1:0]            cnt [POOL_SLOTS];
  logic [SlotW-1:0]      order [POOL_SLOTS];
  logic [LenW-1:0]       len;
  logic [LenW-1:0]       rem;
  logic [SlotW-1:0]      scan;
  logic [SlotW-1:0]      hit;
  logic                  found;
  logic [TAG_W-1:0]      tag_mem [POOL_SLOTS];
  logic [TAG_W-1:0]      tag_rdata;
  logic                  res_valid;
  logic                  res_load;
  result_t               res_next;

  logic [SlotW-1:0]      cmd_slot;
  logic [SlotW-1:0]      head;
  logic [LenW-1:0]       len_m1;
  logic                  step_remove;
  logic                  step_hit;
  logic                  last_step;
  logic                  found_now;
  logic                  append;
  logic [SlotW-1:0]      append_slot;

  // The arrival list rotates through its head, one entry per cycle.
  assign cmd_slot  = SlotW'(cmd.handle);
  assign head      = order[0];
  assign len_m1    = len - LenW'(1);
  assign last_step = (rem == LenW'(1));

  assign step_remove = (mode == MODE_SWEEP && taken[head] && cnt[head] == 2'd1) ||
                       (mode == MODE_EVICT && !found && !taken[head]);
  assign step_hit    = (mode != MODE_SWEEP) && !found && !taken[head];
  assign found_now   = found || step_hit;

  // A slot joins the tail when a free slot is found or an evicted slot is reused.
  always_comb begin
    append      = 1'b0;
    append_slot = scan;
    if (state == ST_SCAN && !valid[scan]) begin
      append = 1'b1;
    end else if (state == ST_READ && mode == MODE_EVICT) begin
      append      = 1'b1;
      append_slot = hit;
    end
  end

  // Dispatch and result selection.
  always_comb begin
    cmd_pop  = 1'b0;
    res_load = 1'b0;
    res_next = '0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid && !res_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            CMD_NOP: begin
              res_load = 1'b1;
            end
            CMD_RELEASE_BAD: begin
              res_load            = 1'b1;
              res_next.status     = STATUS_REL_EMPTY;
              res_next.slot_index = cmd.handle;
            end
            CMD_RELEASE: begin
              if (!valid[cmd_slot]) begin
                res_load            = 1'b1;
                res_next.status     = STATUS_REL_EMPTY;
                res_next.slot_index = cmd.handle;
              end
            end
            CMD_GET: begin
              if (len == '0) begin
                res_load        = 1'b1;
                res_next.status = STATUS_NOTHING;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (!valid[scan]) begin
          res_load            = 1'b1;
          res_next.slot_index = SLOT_INDEX_W'(scan);
        end
      end
      ST_ROT: begin
        if (last_step) begin
          case (mode)
            MODE_SWEEP: begin
              res_load            = 1'b1;
              res_next.slot_index = cur.handle;
            end
            MODE_GET: begin
              if (!found_now) begin
                res_load        = 1'b1;
                res_next.status = STATUS_NOTHING;
              end
            end
            MODE_EVICT: begin
              if (!found_now) begin
                res_load        = 1'b1;
                res_next.status = STATUS_ADD_DROPPED;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RESP: begin
        res_load            = 1'b1;
        res_next.slot_index = SLOT_INDEX_W'(hit);
        if (mode == MODE_EVICT) begin
          res_next.evicted     = 1'b1;
          res_next.evicted_tag = tag_rdata;
        end else begin
          res_next.out_tag = tag_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer and per-slot flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mode      <= MODE_GET;
      found     <= 1'b0;
      valid     <= '0;
      taken     <= '0;
      len       <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < POOL_SLOTS; i++) begin
        cnt[i] <= 2'd0;
      end
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !out_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            found <= 1'b0;
            case (cmd.kind)
              CMD_ADD: begin
                if (len != Full) begin
                  state <= ST_SCAN;
                end else begin
                  state <= ST_ROT;
                  mode  <= MODE_EVICT;
                end
              end
              CMD_GET: begin
                if (len != '0) begin
                  state <= ST_ROT;
                  mode  <= MODE_GET;
                end
              end
              CMD_RELEASE: begin
                if (valid[cmd_slot]) begin
                  if (cnt[cmd_slot] != 2'd3) begin
                    cnt[cmd_slot] <= cnt[cmd_slot] + 2'd1;
                  end
                  state <= ST_ROT;
                  mode  <= MODE_SWEEP;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (!valid[scan]) begin
            valid[scan] <= 1'b1;
            taken[scan] <= 1'b0;
            cnt[scan]   <= 2'd0;
            len         <= len + LenW'(1);
            state       <= ST_IDLE;
          end
        end
        ST_ROT: begin
          if (step_remove) begin
            len <= len_m1;
            if (mode == MODE_SWEEP) begin
              valid[head] <= 1'b0;
              taken[head] <= 1'b0;
              cnt[head]   <= 2'd0;
            end
          end
          if (step_hit) begin
            found <= 1'b1;
            if (mode == MODE_GET) begin
              taken[head] <= 1'b1;
            end
          end
          if (last_step) begin
            state <= (found_now && mode != MODE_SWEEP) ? ST_READ : ST_IDLE;
          end
        end
        ST_READ: begin
          if (mode == MODE_EVICT) begin
            taken[hit] <= 1'b0;
            cnt[hit]   <= 2'd0;
            len        <= len + LenW'(1);
          end
          state <= ST_RESP;
        end
        ST_RESP: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Working registers and the arrival list; none of them needs a reset.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur  <= cmd;
      rem  <= len;
      scan <= '0;
    end
    if (state == ST_SCAN) begin
      scan <= scan + SlotW'(1);
    end
    if (state == ST_ROT) begin
      rem <= rem - LenW'(1);
      if (step_hit) begin
        hit <= head;
      end
    end
    for (int i = 0; i < POOL_SLOTS - 1; i++) begin
      if (state == ST_ROT) begin
        if (!step_remove && LenW'(i) == len_m1) begin
          order[i] <= head;
        end else begin
          order[i] <= order[i+1];
        end
      end else if (append && LenW'(i) == len) begin
        order[i] <= append_slot;
      end
    end
    if (state == ST_ROT) begin
      if (!step_remove && len_m1 == LenW'(POOL_SLOTS - 1)) begin
        order[POOL_SLOTS-1] <= head;
      end
    end else if (append && len == LenW'(POOL_SLOTS - 1)) begin
      order[POOL_SLOTS-1] <= append_slot;
    end
    if (res_load) begin
      res <= res_next;
    end
  end

  // Tag memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (append) begin
      tag_mem[append_slot] <= cur.tag;
    end
    if (state == ST_READ) begin
      tag_rdata <= tag_mem[hit];
    end
  end

  assign out_valid = res_valid;

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= Full)
    else $error("pool length beyond pool size");

  a_len_matches_valid: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> $countones(valid) == int'(len))
    else $error("valid slots disagree with arrival list length");

  a_taken_implies_valid: assert property (@(posedge clk) disable iff (rst)
    (taken & ~valid) == '0)
    else $error("taken flag on a free slot");

  a_result_not_overwritten: assert property (@(posedge clk) disable iff (rst)
    res_load |-> !res_valid)
    else $error("result register overwritten before delivery");

endmodule

@@ design/frame_slot_pool_manager.sv @@
`timescale 1ns / 1ps
// An unused opcode, a bad release, a release of a free slot or a get from an empty pool
// is answered at dispatch; an add into a pool with room scans for a free slot, one slot
// per cycle, and get, release and full-pool add rotate the arrival list through its
// head, one entry per cycle.
// One item is worked at a time; a two-entry queue takes new beats meanwhile.
// Reset empties the pool at once; the tag memory is not cleared.
module frame_slot_pool_manager #(
  parameter int POOL_SLOTS = fspm_pkg::DEFAULT_POOL_SLOTS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [fspm_pkg::OPCODE_W-1:0]       opcode,
  input  logic [fspm_pkg::TAG_W-1:0]          frame_tag,
  input  logic [fspm_pkg::HANDLE_W-1:0]       slot_handle,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [fspm_pkg::STATUS_W-1:0]       status,
  output logic [fspm_pkg::SLOT_INDEX_W-1:0]   slot_index,
  output logic [fspm_pkg::TAG_W-1:0]          out_tag,
  output logic                                evicted,
  output logic [fspm_pkg::TAG_W-1:0]          evicted_tag
);
  import fspm_pkg::*;

  logic    cmd_valid;
  logic    cmd_pop;
  cmd_t    cmd;
  result_t res;

  // Front end: classify beats and queue them.
  fspm_front #(
    .POOL_SLOTS(POOL_SLOTS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .frame_tag   (frame_tag),
    .slot_handle (slot_handle),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop),
    .cmd         (cmd)
  );

  // Back end: pool state, scans and the result register.
  fspm_back #(
    .POOL_SLOTS(POOL_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  // Result fields to their ports.
  assign status      = res.status;
  assign slot_index  = res.slot_index;
  assign out_tag     = res.out_tag;
  assign evicted     = res.evicted;
  assign evicted_tag = res.evicted_tag;

endmodule

@@ tb/frame_slot_pool_manager_tb.sv @@
`timescale 1ns / 1ps

module frame_slot_pool_manager_tb;
  import fspm_pkg::*;

  localparam int SLOTS = DEFAULT_POOL_SLOTS;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 550;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 200000;
  localparam int IDLE_PERCENT = 24;

  // Tracks the slot pool and holds the replies still owed by the block.
  class slot_pool_scoreboard;
    bit                  slot_used[SLOTS];
    logic [TAG_W-1:0]    slot_frame[SLOTS];
    bit                  slot_held[SLOTS];
    bit [1:0]            slot_releases[SLOTS];
    int                  age_list[$];
    result_t             replies_due[$];
    int                  errors;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_frame[i] = '0;
        slot_held[i] = 1'b0;
        slot_releases[i] = 2'd0;
      end
      errors = 0;
    endfunction

    // Frees every held slot whose release count is exactly one.
    function void free_released();
      int pos;
      int s;
      pos = 0;
      while (pos < age_list.size()) begin
        s = age_list[pos];
        if (slot_held[s] && slot_releases[s] == 2'd1) begin
          slot_used[s] = 1'b0;
          slot_held[s] = 1'b0;
          slot_releases[s] = 2'd0;
          age_list.delete(pos);
        end else begin
          pos++;
        end
      end
    endfunction

    // Applies one accepted command and queues the reply it should produce.
    function void note_command(logic [OPCODE_W-1:0] op, logic [TAG_W-1:0] tag,
                               logic [HANDLE_W-1:0] hnd);
      result_t r;
      bit have;
      int s;
      r = '0;
      have = 1'b0;
      s = 0;
      case (op)
        OP_ADD: begin
          if (age_list.size() < SLOTS) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (!have && !slot_used[i]) begin
                s = i;
                have = 1'b1;
              end
            end
          end else begin
            // Full pool: the oldest frame nobody holds makes room.
            for (int i = 0; i < age_list.size(); i++) begin
              if (!have && !slot_held[age_list[i]]) begin
                s = age_list[i];
                have = 1'b1;
                r.evicted = 1'b1;
                r.evicted_tag = slot_frame[s];
                age_list.delete(i);
              end
            end
          end
          if (have) begin
            slot_used[s] = 1'b1;
            slot_frame[s] = tag;
            slot_held[s] = 1'b0;
            slot_releases[s] = 2'd0;
            age_list.push_back(s);
            r.slot_index = s[SLOT_INDEX_W-1:0];
          end else begin
            r.status = STATUS_ADD_DROPPED;
          end
        end
        OP_GET: begin
          r.status = STATUS_NOTHING;
          for (int i = 0; i < age_list.size(); i++) begin
            s = age_list[i];
            if (!have && slot_used[s] && !slot_held[s]) begin
              have = 1'b1;
              slot_held[s] = 1'b1;
              r.status = STATUS_OK;
              r.slot_index = s[SLOT_INDEX_W-1:0];
              r.out_tag = slot_frame[s];
            end
          end
        end
        OP_RELEASE: begin
          r.slot_index = hnd;
          if (!slot_used[hnd]) begin
            r.status = STATUS_REL_EMPTY;
          end else begin
            if (slot_releases[hnd] != 2'd3) slot_releases[hnd]++;
            free_released();
          end
        end
        default: begin
        end
      endcase
      replies_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [TAG_W-1:0] want, logic [TAG_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // Compares one reply beat with the oldest reply owed.
    function void check_reply(logic [STATUS_W-1:0] st, logic [SLOT_INDEX_W-1:0] idx,
                              logic [TAG_W-1:0] otag, logic ev, logic [TAG_W-1:0] evtag);
      result_t want;
      if (replies_due.size() == 0) begin
        $error("reply beat with no command outstanding: status %0d slot %0d", st, idx);
        errors++;
      end else begin
        want = replies_due.pop_front();
        compare_field("status", TAG_W'(want.status), TAG_W'(st));
        compare_field("slot_index", TAG_W'(want.slot_index), TAG_W'(idx));
        compare_field("out_tag", want.out_tag, otag);
        compare_field("evicted", TAG_W'(want.evicted), TAG_W'(ev));
        compare_field("evicted_tag", want.evicted_tag, evtag);
      end
    endfunction

    // Picks a random valid slot that is held or not held, or -1 if none.
    function int random_slot(bit want_held);
      int cand[$];
      foreach (slot_used[i]) begin
        if (slot_used[i] && slot_held[i] == want_held) cand.push_back(i);
      end
      if (cand.size() == 0) return -1;
      return cand[$urandom_range(cand.size() - 1)];
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [OPCODE_W-1:0]     opcode = '0;
  logic [TAG_W-1:0]        frame_tag = '0;
  logic [HANDLE_W-1:0]     slot_handle = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [STATUS_W-1:0]     status;
  logic [SLOT_INDEX_W-1:0] slot_index;
  logic [TAG_W-1:0]        out_tag;
  logic                    evicted;
  logic [TAG_W-1:0]        evicted_tag;

  bit                      no_idle = 1'b0;
  int                      cycle_count = 0;
  slot_pool_scoreboard     book;

  frame_slot_pool_manager #(
    .POOL_SLOTS (SLOTS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .frame_tag   (frame_tag),
    .slot_handle (slot_handle),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .slot_index  (slot_index),
    .out_tag     (out_tag),
    .evicted     (evicted),
    .evicted_tag (evicted_tag)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Random back-pressure on the reply side.
  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
  end

  // Check every reply beat that the block hands over.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      book.check_reply(status, slot_index, out_tag, evicted, evicted_tag);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("frame_slot_pool_manager_tb: done, errors");
      $finish;
    end
  end

  // Sends one command beat, with random idle cycles ahead of it.
  task automatic put_beat(input logic [OPCODE_W-1:0] op, input logic [TAG_W-1:0] tag,
                          input logic [HANDLE_W-1:0] hnd);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    frame_tag <= tag;
    slot_handle <= hnd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_command(op, tag, hnd);
  endtask

  initial begin
    int pick;
    int s;
    book = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty pool: nothing to get, release of an empty slot, unused opcode.
    put_beat(OP_GET, 32'h0, 3'd0);
    put_beat(OP_RELEASE, 32'hFFFF_FFFF, 3'd7);
    put_beat(OP_UNUSED, 32'hFFFF_FFFF, 3'd7);

    // Fill the pool, extremes of the tag first.
    put_beat(OP_ADD, 32'h0000_0000, 3'd0);
    put_beat(OP_ADD, 32'hFFFF_FFFF, 3'd7);
    for (int i = 2; i < SLOTS; i++) put_beat(OP_ADD, $urandom, 3'd0);

    // Saturate the release count of an untaken slot, then evict it.
    repeat (4) put_beat(OP_RELEASE, 32'h0, 3'd0);
    put_beat(OP_ADD, 32'hA5A5_A5A5, 3'd0);

    // Release an untaken slot once; it is freed after it is taken.
    put_beat(OP_RELEASE, 32'h0, 3'd1);
    repeat (SLOTS + 1) put_beat(OP_GET, 32'h0, 3'd0);

    // Every slot taken: add is dropped; then a release frees slots.
    put_beat(OP_ADD, 32'h1234_5678, 3'd0);
    put_beat(OP_RELEASE, 32'h0, 3'd3);

    // Random traffic, mostly add / get / release of held slots.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 250 && n < 350);
      pick = $urandom_range(99);
      if (pick < 38) begin
        put_beat(OP_ADD, $urandom, HANDLE_W'($urandom_range(7)));
      end else if (pick < 66) begin
        put_beat(OP_GET, $urandom, HANDLE_W'($urandom_range(7)));
      end else if (pick < 95) begin
        pick = $urandom_range(99);
        s = book.random_slot(1'b1);
        if (pick < 90 && s >= 0) begin
          put_beat(OP_RELEASE, $urandom, s[HANDLE_W-1:0]);
        end else if (pick < 93) begin
          s = book.random_slot(1'b0);
          if (s >= 0) put_beat(OP_RELEASE, $urandom, s[HANDLE_W-1:0]);
          else put_beat(OP_GET, $urandom, HANDLE_W'($urandom_range(7)));
        end else if (pick >= 97) begin
          put_beat(OP_RELEASE, $urandom, HANDLE_W'($urandom_range(7)));
        end else begin
          put_beat(OP_GET, $urandom, HANDLE_W'($urandom_range(7)));
        end
      end else begin
        put_beat(OP_UNUSED, $urandom, HANDLE_W'($urandom_range(7)));
      end
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    // Drain the outstanding replies, then watch for strays.
    while (book.replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.errors == 0) begin
      $display("frame_slot_pool_manager_tb: done, clean");
    end else begin
      $display("frame_slot_pool_manager_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ frame_slot_pool_manager.f @@
design/fspm_pkg.sv
design/fspm_front.sv
design/fspm_back.sv
design/frame_slot_pool_manager.sv
tb/frame_slot_pool_manager_tb.sv
